// ----- rtl/core/iscc_pkg.sv -----
// iscc_pkg: shared types and constants of the interpolation search counter
// no dependencies
package iscc_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

    typedef struct packed
    {
        logic                 search;
        logic [INDEX_W-1:0]   entry_index;
        logic [VALUE_W-1:0]   item_value;
    } op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD_BOUNDS,
        ST_WAIT_BOUNDS,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_RD_PROBE,
        ST_WAIT_PROBE,
        ST_COMPARE,
        ST_DONE
    } exec_state_t;

endpackage

// ----- rtl/core/iscc_if.sv -----
// iscc_if: valid/ready channel interfaces for input and result words
// depends on iscc_pkg
interface iscc_in_if
    import iscc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [INDEX_W-1:0]   entry_index;
    logic [VALUE_W-1:0]   item_value;

    modport source (output valid, command, entry_index, item_value, input ready);
    modport sink (input valid, command, entry_index, item_value, output ready);
endinterface

interface iscc_out_if
    import iscc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   compare_count;
    logic                 found;

    modport source (output valid, compare_count, found, input ready);
    modport sink (input valid, compare_count, found, output ready);
endinterface

// ----- rtl/core/iscc_front.sv -----
// iscc_front: accepts input words, classifies them and queues them
// depends on iscc_pkg
module iscc_front
    import iscc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     in_command,
    input  logic [INDEX_W-1:0] in_entry_index,
    input  logic [VALUE_W-1:0] in_item_value,
    output logic     op_valid,
    input  logic     op_ready,
    output op_t      op
);
    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;
    op_t              in_op;

    assign in_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign op_valid = (fill_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = op_valid && op_ready;
    assign op = queue_reg[rd_ptr_reg];

    always_comb
    begin
        in_op.search = (cmd_t'(in_command) == CMD_SEARCH);
        in_op.entry_index = in_entry_index;
        in_op.item_value = in_item_value;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_op;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 1'b1) else $error("fill lost");
    a_empty_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> !op_valid) else $error("valid on empty queue");
endmodule

// ----- rtl/core/iscc_back.sv -----
// iscc_back: table memory, interpolation probe sequencer with serial divider
// depends on iscc_pkg
module iscc_back
    import iscc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  op_t                op,
    input  logic [SIZE_W-1:0]  table_size,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [COUNT_W-1:0] res_count,
    output logic               res_found
);
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned BND_W = ADDR_W + 1;
    localparam int unsigned SPAN_W = ADDR_W;
    localparam int unsigned NUM_W = VALUE_W + SPAN_W;
    localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
    localparam int unsigned SZ_W = (SIZE_W > BND_W) ? SIZE_W : BND_W;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]  addr_a, addr_b;

    exec_state_t        state_reg, state_next;
    logic [BND_W-1:0]   low_reg, low_next, high_reg, high_next;
    logic [VALUE_W-1:0] target_reg, target_next;
    logic [VALUE_W-1:0] vlo_reg, vlo_next, dv_reg, dv_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [VALUE_W:0]   rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               found_reg, found_next;
    logic               res_valid_reg, res_valid_next;
    logic [VALUE_W:0]   rem_shift;
    logic [SZ_W-1:0]    n_eff;
    logic               load_write;

    // low/high are stored offset: high holds hi+1 so that hi = -1 is representable
    always_comb
    begin
        if (SZ_W'(table_size) > SZ_W'(TABLE_DEPTH))
        begin
            n_eff = SZ_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = SZ_W'(table_size);
        end
    end

    // probe address held through the probe read and wait states
    assign addr_a = low_reg[ADDR_W-1:0];
    assign addr_b = (state_reg == ST_RD_PROBE || state_reg == ST_WAIT_PROBE)
        ? pos_reg : ADDR_W'(high_reg - 1'b1);
    assign load_write = op_valid && op_ready && !op.search
        && (32'(op.entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            mem[ADDR_W'(op.entry_index)] <= op.item_value;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    assign rem_shift = {rem_reg[VALUE_W-1:0], num_reg[NUM_W-1]};

    always_comb
    begin
        state_next = state_reg;
        low_next = low_reg;
        high_next = high_reg;
        target_next = target_reg;
        vlo_next = vlo_reg;
        dv_next = dv_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        pos_next = pos_reg;
        count_next = count_reg;
        found_next = found_reg;
        res_valid_next = res_valid_reg;
        op_ready = 1'b0;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                op_ready = !res_valid_reg || res_ready;
                if (op_valid && op_ready)
                begin
                    count_next = '0;
                    found_next = 1'b0;
                    target_next = op.item_value;
                    low_next = '0;
                    high_next = BND_W'(n_eff);
                    if (op.search && n_eff != '0)
                    begin
                        state_next = ST_RD_BOUNDS;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_RD_BOUNDS:
            begin
                if (low_reg >= high_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WAIT_BOUNDS;
                end
            end
            ST_WAIT_BOUNDS:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                vlo_next = rd_a_reg;
                dv_next = rd_b_reg - rd_a_reg;
                if (target_reg < rd_a_reg || target_reg > rd_b_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (rd_a_reg == rd_b_reg)
                begin
                    pos_next = low_reg[ADDR_W-1:0];
                    state_next = ST_RD_PROBE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                num_next = NUM_W'(target_reg - vlo_reg)
                    * NUM_W'(SPAN_W'(high_reg - 1'b1 - low_reg));
                rem_next = '0;
                dcnt_next = DCNT_W'(NUM_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_shift >= {1'b0, dv_reg})
                begin
                    rem_next = rem_shift - {1'b0, dv_reg};
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    pos_next = low_reg[ADDR_W-1:0] + num_next[ADDR_W-1:0];
                    state_next = ST_RD_PROBE;
                end
            end
            ST_RD_PROBE:
            begin
                state_next = ST_WAIT_PROBE;
            end
            ST_WAIT_PROBE:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (rd_b_reg == target_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (count_reg < COUNT_MAX - 1'b1)
                    begin
                        count_next = count_reg + COUNT_W'(2);
                    end
                    else
                    begin
                        count_next = COUNT_MAX;
                    end
                    if (rd_b_reg < target_reg)
                    begin
                        low_next = BND_W'(pos_reg) + 1'b1;
                    end
                    else
                    begin
                        high_next = BND_W'(pos_reg);
                    end
                    state_next = ST_RD_BOUNDS;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
        high_reg <= high_next;
        target_reg <= target_next;
        vlo_reg <= vlo_next;
        dv_reg <= dv_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;
        pos_reg <= pos_next;
        count_reg <= count_next;
        found_reg <= found_next;
    end

    assign res_valid = res_valid_reg;
    assign res_count = count_reg;
    assign res_found = found_reg;

    a_probe_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_PROBE) |-> (BND_W'(pos_reg) >= low_reg
        && BND_W'(pos_reg) < high_reg)) else $error("probe outside bounds");
    a_found_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && count_reg == '0) |-> !found_reg) else $error("found without compare");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(count_reg))
        else $error("result dropped");
endmodule

// ----- rtl/core/interpolation_search_compare_count_top.sv -----
// interpolation_search_compare_count_top: apb register, front queue, search back end
// depends on iscc_pkg, iscc_if, iscc_front, iscc_back
//
// channel   | dir | payload                             | handshake
// in_ch     | in  | command, entry_index, item_value    | valid/ready
// out_ch    | out | compare_count, found                | valid/ready
// apb       | in  | table_size at byte address 0        | psel/penable, pready high
//
// a load or a zero-size search gives its result word the cycle after the back end takes it
// a search reads both bounds, waits and checks the range, and per probe does a multiply,
// a serial divide (one quotient bit per value bit plus address bit) and a probe read,
// wait and compare; equal bound values skip multiply and divide
// a waiting result word holds up the done state and holds off the next queued word
// the 2-entry queue lets the front take words while the back end works a search
// reset leaves table_size at 1024; table contents are undefined until loaded
module interpolation_search_compare_count_top
    import iscc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    iscc_in_if.sink     in_ch,
    iscc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [SIZE_W-1:0] table_size_reg;
    logic              op_valid, op_ready;
    op_t               op;

    // single register, addressed by word
    assign pready = 1'b1;
    assign prdata = (paddr[1] == REG_TABLE_SIZE) ? 32'(table_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_W'(1024);
        end
        else if (psel && penable && pwrite && paddr[1] == REG_TABLE_SIZE)
        begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // front: accept and queue words
    iscc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .in_command(in_ch.command),
        .in_entry_index(in_ch.entry_index),
        .in_item_value(in_ch.item_value),
        .op_valid(op_valid),
        .op_ready(op_ready),
        .op(op)
    );

    // back: table memory and probe sequencer
    iscc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .op_valid(op_valid),
        .op_ready(op_ready),
        .op(op),
        .table_size(table_size_reg),
        .res_valid(out_ch.valid),
        .res_ready(out_ch.ready),
        .res_count(out_ch.compare_count),
        .res_found(out_ch.found)
    );
endmodule
